/* sv/pic_pkg.sv */
`timescale 1ns / 1ps

package pic_pkg;

  localparam int FRAC_BITS = 10;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [15:0]        PROP_GAIN_RESET  = 16'd2048;
  localparam logic [15:0]        INTEG_GAIN_RESET = 16'd20;
  localparam logic [15:0]        TIME_STEP_RESET  = 16'd1024;
  localparam logic signed [31:0] INTEG_HIGH_RESET = 32'sd1048576;
  localparam logic signed [31:0] INTEG_LOW_RESET  = -32'sd1048576;
  localparam logic signed [31:0] OUT_LOW_RESET    = 32'sh8000_0000;
  localparam logic signed [31:0] OUT_HIGH_RESET   = 32'sh7FFF_FFFF;

  // register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_TIME_STEP  = 3'd2,
    REG_INTEG_HIGH = 3'd3,
    REG_INTEG_LOW  = 3'd4,
    REG_OUT_LOW    = 3'd5,
    REG_OUT_HIGH   = 3'd6
  } pic_reg_idx_t;

  typedef struct packed {
    logic [15:0]        prop_gain;
    logic [15:0]        integ_gain;
    logic [15:0]        time_step;
    logic signed [31:0] integ_high;
    logic signed [31:0] integ_low;
    logic signed [31:0] out_low;
    logic signed [31:0] out_high;
  } pic_cfg_t;

  // operand pairing for the shared multiplier
  typedef enum logic [1:0] {
    MUL_ERR_TS  = 2'd0,
    MUL_ERR_KP  = 2'd1,
    MUL_INTG_KI = 2'd2
  } pic_mul_sel_t;

  typedef struct packed {
    logic         load_in;
    logic         mul_en;
    pic_mul_sel_t mul_sel;
    logic         integ_step;
    logic         integ_zero;
    logic         acc_step;
    logic         out_load;
  } pic_cmd_t;

  typedef struct packed {
    logic item_clear;
  } pic_status_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_INTEG = 5'b00100,
    ST_PROP  = 5'b01000,
    ST_DRIVE = 5'b10000
  } pic_state_t;

endpackage

/* sv/pic_if.sv */
`timescale 1ns / 1ps

interface pic_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] err_sample;
  logic               clear;

  modport source (output valid, output err_sample, output clear, input ready);
  modport sink   (input valid, input err_sample, input clear, output ready);
endinterface

interface pic_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               integ_saturated;

  modport source (output valid, output drive, output integ_saturated, input ready);
  modport sink   (input valid, input drive, input integ_saturated, output ready);
endinterface

/* sv/pic_regs.sv */
`timescale 1ns / 1ps

module pic_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pic_pkg::ADDR_W-1:0] paddr,
  input  logic [pic_pkg::DATA_W-1:0] pwdata,
  output logic [pic_pkg::DATA_W-1:0] prdata,
  output pic_pkg::pic_cfg_t          cfg
);

  pic_pkg::pic_reg_idx_t idx;
  logic                  wr_en;

  assign idx   = pic_pkg::pic_reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain  <= pic_pkg::PROP_GAIN_RESET;
      cfg.integ_gain <= pic_pkg::INTEG_GAIN_RESET;
      cfg.time_step  <= pic_pkg::TIME_STEP_RESET;
      cfg.integ_high <= pic_pkg::INTEG_HIGH_RESET;
      cfg.integ_low  <= pic_pkg::INTEG_LOW_RESET;
      cfg.out_low    <= pic_pkg::OUT_LOW_RESET;
      cfg.out_high   <= pic_pkg::OUT_HIGH_RESET;
    end else if (wr_en) begin
      case (idx)
        pic_pkg::REG_PROP_GAIN:  cfg.prop_gain  <= pwdata[15:0];
        pic_pkg::REG_INTEG_GAIN: cfg.integ_gain <= pwdata[15:0];
        pic_pkg::REG_TIME_STEP:  cfg.time_step  <= pwdata[15:0];
        pic_pkg::REG_INTEG_HIGH: cfg.integ_high <= pwdata;
        pic_pkg::REG_INTEG_LOW:  cfg.integ_low  <= pwdata;
        pic_pkg::REG_OUT_LOW:    cfg.out_low    <= pwdata;
        pic_pkg::REG_OUT_HIGH:   cfg.out_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pic_pkg::REG_PROP_GAIN:  prdata = {16'd0, cfg.prop_gain};
      pic_pkg::REG_INTEG_GAIN: prdata = {16'd0, cfg.integ_gain};
      pic_pkg::REG_TIME_STEP:  prdata = {16'd0, cfg.time_step};
      pic_pkg::REG_INTEG_HIGH: prdata = cfg.integ_high;
      pic_pkg::REG_INTEG_LOW:  prdata = cfg.integ_low;
      pic_pkg::REG_OUT_LOW:    prdata = cfg.out_low;
      pic_pkg::REG_OUT_HIGH:   prdata = cfg.out_high;
      default:                 prdata = '0;
    endcase
  end

endmodule

/* sv/pic_ctrl.sv */
`timescale 1ns / 1ps

module pic_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pic_pkg::pic_status_t status,
  output pic_pkg::pic_cmd_t    cmd
);

  pic_pkg::pic_state_t state, state_next;
  logic                out_load;
  logic                accept;

  assign out_load = (state == pic_pkg::ST_DRIVE) && (!out_valid || out_ready);
  // a new sample may enter in the cycle the previous result is registered
  assign in_ready = (state == pic_pkg::ST_IDLE) || out_load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = pic_pkg::MUL_ERR_TS;
    cmd.load_in  = accept;
    cmd.out_load = out_load;
    state_next   = state;
    case (state)
      pic_pkg::ST_IDLE: begin
        if (accept) state_next = pic_pkg::ST_MUL;
      end
      pic_pkg::ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pic_pkg::MUL_ERR_TS;
        if (status.item_clear) begin
          cmd.integ_zero = 1'b1;
          state_next     = pic_pkg::ST_DRIVE;
        end else begin
          state_next = pic_pkg::ST_INTEG;
        end
      end
      pic_pkg::ST_INTEG: begin
        cmd.integ_step = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = pic_pkg::MUL_ERR_KP;
        state_next     = pic_pkg::ST_PROP;
      end
      pic_pkg::ST_PROP: begin
        cmd.acc_step = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = pic_pkg::MUL_INTG_KI;
        state_next   = pic_pkg::ST_DRIVE;
      end
      pic_pkg::ST_DRIVE: begin
        if (out_load) state_next = accept ? pic_pkg::ST_MUL : pic_pkg::ST_IDLE;
      end
      default: state_next = pic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pic_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* sv/pic_dp.sv */
`timescale 1ns / 1ps

module pic_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pic_pkg::pic_cfg_t    cfg,
  input  pic_pkg::pic_cmd_t    cmd,
  output pic_pkg::pic_status_t status,
  input  logic signed [15:0]   err_sample,
  input  logic                 clear,
  output logic signed [31:0]   drive,
  output logic                 integ_saturated
);

  localparam int FB = pic_pkg::FRAC_BITS;

  logic signed [15:0] err;
  logic               clr_item;
  logic signed [31:0] integrator;
  logic signed [49:0] prod;
  logic signed [32:0] acc;
  logic               sat_pend;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod_next;

  logic signed [33:0] sum;
  logic signed [31:0] integ_next;
  logic               sat_next;

  logic signed [40:0] total;
  logic signed [31:0] dv;
  logic signed [31:0] drive_next;

  assign status.item_clear = clr_item;

  // shared 33x17 signed multiplier, gains enter zero-extended
  always_comb begin
    case (cmd.mul_sel)
      pic_pkg::MUL_ERR_TS: begin
        mul_a = 33'(err);
        mul_b = $signed({1'b0, cfg.time_step});
      end
      pic_pkg::MUL_ERR_KP: begin
        mul_a = 33'(err);
        mul_b = $signed({1'b0, cfg.prop_gain});
      end
      pic_pkg::MUL_INTG_KI: begin
        mul_a = 33'(integrator);
        mul_b = $signed({1'b0, cfg.integ_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = 50'(mul_a) * 50'(mul_b);
  end

  // integrator update: upper bound tested first
  always_comb begin
    sum = 34'(integrator) + prod[33:0];
    if (sum > 34'(cfg.integ_high)) begin
      integ_next = cfg.integ_high;
      sat_next   = 1'b1;
    end else if (sum < 34'(cfg.integ_low)) begin
      integ_next = cfg.integ_low;
      sat_next   = 1'b1;
    end else begin
      integ_next = sum[31:0];
      sat_next   = 1'b0;
    end
  end

  // drive = (kp*err + (ki*integ >>> 10)) >>> 10, then clamp
  always_comb begin
    total = 41'(acc) + 41'($signed(prod[49:FB]));
    dv    = 32'($signed(total[40:FB]));
    if (dv <= cfg.out_low)       drive_next = cfg.out_low;
    else if (dv >= cfg.out_high) drive_next = cfg.out_high;
    else                         drive_next = dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
    end else if (cmd.integ_zero) begin
      integrator <= '0;
    end else if (cmd.integ_step) begin
      integrator <= integ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err      <= err_sample;
      clr_item <= clear;
    end
    if (cmd.mul_en) prod <= prod_next;
    if (cmd.integ_step) sat_pend <= sat_next;
    if (cmd.acc_step) acc <= prod[32:0];
    if (cmd.out_load) begin
      drive           <= clr_item ? 32'sd0 : drive_next;
      integ_saturated <= clr_item ? 1'b0 : sat_pend;
    end
  end

endmodule

/* sv/pi_controller_clamped.sv */
`timescale 1ns / 1ps

// Fixed-point PI controller with a clamped integrator. Each sample transaction
// carries a signed error and a clear flag; each produces one result
// transaction with the clamped drive value and an integrator saturation flag.
// A single shared 33x17 multiplier forms err*time_step, prop_gain*err and
// integ_gain*integrator in turn, and the integrator update sits between the
// first and last product. A clear sample zeroes the integrator and the drive.
// The next sample is taken in the cycle the current result is registered, so
// a result waiting at the output does not hold off a new sample unless the
// following one is done too. Gains are unsigned Q10; shifts are arithmetic
// (floor). Registers sit on an APB port at byte addresses 4*index, always
// ready; the user must ensure they are written only while idle (not enforced).

module pi_controller_clamped (
  input  logic                       clk,
  input  logic                       rst,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pic_pkg::ADDR_W-1:0] paddr,
  input  logic [pic_pkg::DATA_W-1:0] pwdata,
  output logic [pic_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // streams
  pic_sample_if.sink                 sample,
  pic_result_if.source               result
);

  pic_pkg::pic_cfg_t    cfg;
  pic_pkg::pic_cmd_t    cmd;
  pic_pkg::pic_status_t status;

  assign pready = 1'b1;

  pic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: owns both handshakes and steps the multiplier
  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: integrator, product and output registers
  pic_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .err_sample      (sample.err_sample),
    .clear           (sample.clear),
    .drive           (result.drive),
    .integ_saturated (result.integ_saturated)
  );

endmodule

/* sv/pic_checker.sv */
`timescale 1ns / 1ps

module pic_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [31:0] drive,
  input logic               integ_saturated
);

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(drive)
      && $stable(integ_saturated))
    else $error("result changed while stalled");

  // an accepted sample occupies the multiplier next cycle
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while step in progress");

  // a new result is only registered in a cycle the sample side is open
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_ready))
    else $error("result loaded outside drive step");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind pi_controller_clamped pic_checker u_pic_checker (
  .clk             (clk),
  .rst             (rst),
  .sample_valid    (sample.valid),
  .sample_ready    (sample.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .drive           (result.drive),
  .integ_saturated (result.integ_saturated)
);
